FILE: rtl/rbp_pkg.sv
// Shared types, widths and constants of the ratio bathymetry pixel block.
package rbp_pkg;

	localparam int ZEN_W     = 14;
	localparam int RAD_W     = 18;
	localparam int IRR_W     = 18;
	localparam int MAG_W     = 17;
	localparam int CLASS_W   = 2;
	localparam int DEPTH_W   = 16;
	localparam int CFG_IDX_W = 2;

	// cosine lane
	localparam int COS_W    = 31;
	localparam int ANG_W    = 31;
	localparam int X2_W     = 32;
	localparam int HORNER_N = 5;
	localparam int LAT_COS  = 2 + 3 * HORNER_N;

	// log2 lane
	localparam int LOG_IN_W = 24;
	localparam int LOG_K_W  = 5;
	localparam int LOG_M_W  = 31;
	localparam int FRAC_N   = 16;
	localparam int LOG_W    = 21;
	localparam int LAT_LOG  = 2 + FRAC_N;

	// land test and depth arithmetic
	localparam int BIGN_W  = 23;
	localparam int LANDP_W = 55;
	localparam int L_W     = 22;
	localparam int NUM_W   = 40;
	localparam int DEN_W   = 26;
	localparam int DENU_W  = 25;
	localparam int REM_W   = 41;

	localparam int LAT_FRONT = LAT_COS + 2;
	localparam int LAT_BACK  = LAT_LOG + 4 + DEPTH_W + 1;

	localparam int MID_DEPTH_DEF = 4;

	localparam logic [ZEN_W-1:0]      ZEN_MAX    = 14'd9000;
	localparam logic [ANG_W-1:0]      ANG_SCALE  = 31'd187403;
	localparam logic [COS_W-1:0]      ONE_Q30    = 31'h4000_0000;
	localparam logic [LANDP_W-1:0]    LAND_K     = 55'd122880;
	localparam logic [LOG_IN_W-1:0]   NLW_GAIN   = 24'd125;
	localparam logic signed [NUM_W-1:0] K490     = 40'sd55040;
	localparam logic signed [NUM_W-1:0] K555     = 40'sd52288;
	localparam logic signed [DEN_W-1:0] DEN_K    = 26'sd5;
	localparam logic [DEPTH_W-1:0]    DEPTH_MAX  = 16'hFFFF;
	localparam logic [IRR_W-1:0]      IRR490_RST = 18'd194253;
	localparam logic [IRR_W-1:0]      IRR555_RST = 18'd189440;

	localparam logic [CFG_IDX_W-1:0] REG_IRR_490 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IRR_555 = 2'd1;

	typedef enum logic [CLASS_W-1:0] {
		CLASS_WATER = 2'd0,
		CLASS_LAND  = 2'd1,
		CLASS_NORET = 2'd2
	} pixel_class_t;

	// classified pixel handed from front to back
	typedef struct packed {
		pixel_class_t       cls;
		logic [MAG_W-1:0]   n490;
		logic [MAG_W-1:0]   n555;
	} mid_item_t;

	// divisors of the Horner cosine, innermost first
	function automatic int unsigned horner_div(input int j);
		int unsigned d;
		case (j)
			0:       d = 90;
			1:       d = 56;
			2:       d = 30;
			3:       d = 12;
			default: d = 2;
		endcase
		return d;
	endfunction

endpackage

FILE: rtl/ratio_bathymetry_pixel.sv
// Top level of the log-ratio bathymetry pixel block.
//
// Pixels enter on the s_ stream, one per transfer; each gives exactly one
// result on the m_ stream, in order. m_tuser carries the pixel class (water
// with depth, land, no retrieval), m_tdata the depth in 1/256 m (zero unless
// water). The cfg channel writes the two solar irradiance registers; it is
// always ready and is meant to be used only while no pixel is in flight.
// The classifier holds two 17-stage cosine lanes and the land test; the queue
// lies between it and the depth pipeline (18-stage log2 lanes, ratio terms,
// 16-stage restoring divider). One pixel per cycle sustained while m_tready
// stays high; otherwise the stalls below apply.
// Each pipeline stalls as a whole: the depth pipeline holds when its output
// is valid and m_tready is low; the classifier holds when its last stage is
// valid and the queue between them is full, and that drops s_tready.
// Reset clears all valid flags and queue pointers and loads the irradiance
// registers with their defaults.
module ratio_bathymetry_pixel import rbp_pkg::*; #(
	parameter int MID_DEPTH = MID_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// solar_zenith[13:0], sensor_zenith[27:14], lt_nir[45:28], lt_blue[63:46],
	// nlw_490[81:64], nlw_555[99:82], zero[103:100]
	input  logic [103:0]         s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// depth_est[15:0]
	output logic [DEPTH_W-1:0]   m_tdata,
	// pixel_class[1:0]
	output logic [CLASS_W-1:0]   m_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IRR_W-1:0]     cfg_data
);

	logic [IRR_W-1:0] irr490_q, irr555_q;
	logic             en_front, en_back;
	logic             front_valid;
	mid_item_t        front_item, back_item;
	logic             mid_push, mid_pop, mid_empty, mid_full;
	logic             back_valid;
	pixel_class_t     back_class;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irr490_q <= IRR490_RST;
			irr555_q <= IRR555_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_IRR_490) irr490_q <= cfg_data;
			if (cfg_index == REG_IRR_555) irr555_q <= cfg_data;
		end
	end

	assign en_front = !front_valid || !mid_full;
	assign s_tready = en_front;
	assign mid_push = front_valid && !mid_full;

	rbp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en_front),
		.in_valid     (s_tvalid),
		.solar_zenith (s_tdata[13:0]),
		.sensor_zenith(s_tdata[27:14]),
		.lt_nir       (s_tdata[45:28]),
		.lt_blue      (s_tdata[63:46]),
		.nlw_490      ($signed(s_tdata[81:64])),
		.nlw_555      ($signed(s_tdata[99:82])),
		.out_valid    (front_valid),
		.out_item     (front_item)
	);

	rbp_fifo #(
		.W    ($bits(mid_item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (front_item),
		.pop   (mid_pop),
		.rdata (back_item),
		.empty (mid_empty),
		.full  (mid_full)
	);

	assign en_back = !back_valid || m_tready;
	assign mid_pop = en_back && !mid_empty;

	rbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en_back),
		.in_valid (!mid_empty),
		.in_item  (back_item),
		.irr_490  (irr490_q),
		.irr_555  (irr555_q),
		.out_valid(back_valid),
		.out_class(back_class),
		.out_depth(m_tdata)
	);

	assign m_tvalid = back_valid;
	assign m_tuser  = back_class;

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_full)
		else $error("queue written while full");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (front_valid && mid_full))
		else $error("input stalled without a full queue");

	a_depth_class: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != CLASS_WATER)) |-> (m_tdata == '0))
		else $error("nonzero depth on a non-water pixel");

endmodule

FILE: rtl/rbp_cos.sv
// Pipelined Q30 cosine of a zenith angle given in hundredths of a degree.
module rbp_cos import rbp_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [ZEN_W-1:0] zen,
	output logic [COS_W-1:0] cos_val
);

	logic [ZEN_W-1:0] zc;
	logic [ANG_W-1:0] zc_w;
	logic [ANG_W-1:0] x_s1;
	logic [X2_W-1:0]  x2_s2;
	logic [2*ANG_W-1:0] xx;
	logic [COS_W-1:0] c_st  [HORNER_N+1];
	logic [X2_W-1:0]  x2_st [HORNER_N+1];

	assign zc   = (zen > ZEN_MAX) ? ZEN_MAX : zen;
	assign zc_w = ANG_W'(zc);
	assign xx   = (2*ANG_W)'(x_s1) * (2*ANG_W)'(x_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= zc_w * ANG_SCALE;
			// x^2 >> 30 needs all 32 upper bits at a 90 degree angle
			x2_s2 <= xx[2*ANG_W-1:30];
		end
	end

	assign c_st[0]  = ONE_Q30;
	assign x2_st[0] = x2_s2;

	for (genvar j = 0; j < HORNER_N; j++) begin : g_step
		localparam int unsigned D = horner_div(j);
		localparam logic [63:0] RECIP = (64'd1 << 32) / D;
		localparam logic [X2_W-1:0] DV = X2_W'(D);

		logic [X2_W-1:0]  q_s1, q_s2, x2_s1, x2_s2l, x2_s3;
		logic [X2_W-1:0]  est_s2;
		logic [COS_W-1:0] c_s3;
		logic [62:0]      prod_a;
		logic [63:0]      prod_b;
		logic [X2_W-1:0]  rem, p;

		assign prod_a = 63'(c_st[j]) * 63'(x2_st[j]);
		assign prod_b = 64'(q_s1) * RECIP;
		// estimate is low by at most one
		assign rem    = q_s2 - est_s2 * DV;
		assign p      = (rem >= DV) ? est_s2 + X2_W'(1) : est_s2;

		always_ff @(posedge clk) begin
			if (en) begin
				q_s1   <= prod_a[61:30];
				x2_s1  <= x2_st[j];
				q_s2   <= q_s1;
				est_s2 <= prod_b[63:32];
				x2_s2l <= x2_s1;
				c_s3   <= (p >= X2_W'(ONE_Q30)) ? '0 : COS_W'(X2_W'(ONE_Q30) - p);
				x2_s3  <= x2_s2l;
			end
		end

		assign c_st[j+1]  = c_s3;
		assign x2_st[j+1] = x2_s3;
	end

	assign cos_val = c_st[HORNER_N];

endmodule

FILE: rtl/rbp_log2.sv
// Pipelined log2 in Q16: leading-one search, then one squaring step per fraction bit.
module rbp_log2 import rbp_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [LOG_IN_W-1:0] v,
	output logic [LOG_W-1:0]    r
);

	logic [LOG_K_W-1:0]  k;
	logic [LOG_IN_W-1:0] v_s1;
	logic [LOG_K_W-1:0]  k_s1;
	logic [LOG_M_W-1:0]  m_s2;
	logic [LOG_W-1:0]    r_s2;
	logic [LOG_M_W-1:0]  m_st [FRAC_N+1];
	logic [LOG_W-1:0]    r_st [FRAC_N+1];

	always_comb begin
		k = '0;
		for (int i = 0; i < LOG_IN_W; i++) begin
			if (v[i]) k = LOG_K_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= v;
			k_s1 <= k;
			m_s2 <= LOG_M_W'(v_s1) << (LOG_K_W'(30) - k_s1);
			r_s2 <= LOG_W'(k_s1) << FRAC_N;
		end
	end

	assign m_st[0] = m_s2;
	assign r_st[0] = r_s2;

	for (genvar i = 0; i < FRAC_N; i++) begin : g_bit
		logic [2*LOG_M_W-1:0] sq;
		logic [LOG_M_W:0]     sq_t;
		logic [LOG_M_W-1:0]   m_s1;
		logic [LOG_W-1:0]     r_s1;

		assign sq   = (2*LOG_M_W)'(m_st[i]) * (2*LOG_M_W)'(m_st[i]);
		assign sq_t = sq[2*LOG_M_W-1:30];

		always_ff @(posedge clk) begin
			if (en) begin
				if (sq_t[LOG_M_W]) begin
					m_s1 <= sq_t[LOG_M_W:1];
					r_s1 <= r_st[i] | (LOG_W'(1) << (FRAC_N - 1 - i));
				end else begin
					m_s1 <= sq_t[LOG_M_W-1:0];
					r_s1 <= r_st[i];
				end
			end
		end

		assign m_st[i+1] = m_s1;
		assign r_st[i+1] = r_s1;
	end

	assign r = r_st[FRAC_N];

endmodule

FILE: rtl/rbp_fifo.sv
// Small flop-based queue between the classifier and the depth pipeline.
module rbp_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty,
	output logic         full
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW:0]  wr_q, rd_q;

	assign empty = (wr_q == rd_q);
	assign full  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign rdata = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + (AW+1)'(1);
			if (pop)  rd_q <= rd_q + (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q[AW-1:0]] <= wdata;
	end

endmodule

FILE: rtl/rbp_front.sv
// Front pipeline: zenith cosines, land test and pixel classification.
module rbp_front import rbp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [ZEN_W-1:0]        solar_zenith,
	input  logic [ZEN_W-1:0]        sensor_zenith,
	input  logic [RAD_W-1:0]        lt_nir,
	input  logic [RAD_W-1:0]        lt_blue,
	input  logic signed [RAD_W-1:0] nlw_490,
	input  logic signed [RAD_W-1:0] nlw_555,
	output logic                    out_valid,
	output mid_item_t               out_item
);

	typedef struct packed {
		logic signed [BIGN_W-1:0] big_n;
		logic signed [RAD_W-1:0]  n490;
		logic signed [RAD_W-1:0]  n555;
	} front_carry_t;

	logic [LAT_FRONT-1:0]    valid_q;
	front_carry_t            carry_q [LAT_COS];
	front_carry_t            carry_in;
	front_carry_t            carry_s1;
	logic [COS_W-1:0]        mu0, mu;
	logic signed [BIGN_W-1:0] nir_x, blue_x;
	logic signed [LANDP_W-1:0] mu_sx, n_sx, prod_s1, bias_s1, land_sum;
	logic                    land, pos490, pos555;
	mid_item_t               item_s2;

	rbp_cos u_cos_sun (.clk(clk), .en(en), .zen(solar_zenith), .cos_val(mu0));
	rbp_cos u_cos_view (.clk(clk), .en(en), .zen(sensor_zenith), .cos_val(mu));

	assign nir_x          = $signed(BIGN_W'(lt_nir));
	assign blue_x         = $signed(BIGN_W'(lt_blue));
	assign carry_in.big_n = nir_x * BIGN_W'(10) - blue_x * BIGN_W'(7);
	assign carry_in.n490  = nlw_490;
	assign carry_in.n555  = nlw_555;

	assign mu_sx = $signed(LANDP_W'(mu));
	assign n_sx  = LANDP_W'(carry_q[LAT_COS-1].big_n);

	// land when mu*N + 122880*(mu + mu0) > 0
	assign land_sum = prod_s1 + bias_s1;
	assign land     = !land_sum[LANDP_W-1] && (|land_sum);
	assign pos490   = !carry_s1.n490[RAD_W-1] && (|carry_s1.n490[MAG_W-1:0]);
	assign pos555   = !carry_s1.n555[RAD_W-1] && (|carry_s1.n555[MAG_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[LAT_FRONT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_q[0] <= carry_in;
			for (int i = 1; i < LAT_COS; i++) carry_q[i] <= carry_q[i-1];
			prod_s1  <= mu_sx * n_sx;
			bias_s1  <= $signed(LANDP_W'(32'(mu) + 32'(mu0)) * LAND_K);
			carry_s1 <= carry_q[LAT_COS-1];
			if (land)
				item_s2.cls <= CLASS_LAND;
			else if (!pos490 || !pos555)
				item_s2.cls <= CLASS_NORET;
			else
				item_s2.cls <= CLASS_WATER;
			item_s2.n490 <= carry_s1.n490[MAG_W-1:0];
			item_s2.n555 <= carry_s1.n555[MAG_W-1:0];
		end
	end

	assign out_valid = valid_q[LAT_FRONT-1];
	assign out_item  = item_s2;

endmodule

FILE: rtl/rbp_back.sv
// Back pipeline: band logs, ratio terms and the rounded depth divider.
module rbp_back import rbp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  mid_item_t          in_item,
	input  logic [IRR_W-1:0]   irr_490,
	input  logic [IRR_W-1:0]   irr_555,
	output logic               out_valid,
	output pixel_class_t       out_class,
	output logic [DEPTH_W-1:0] out_depth
);

	typedef struct packed {
		pixel_class_t       cls;
		logic               fmax;
		logic               fzero;
		logic [DENU_W-1:0]  den;
	} div_carry_t;

	logic [LAT_BACK-1:0]   valid_q;
	pixel_class_t          cls_q [LAT_LOG];
	logic [LOG_IN_W-1:0]   v490, v555, f490, f555;
	logic [LOG_W-1:0]      lg490, lg555, lf490, lf555;

	logic signed [L_W-1:0]   l490_s1, l555_s1;
	pixel_class_t            cls_s1, cls_s2, cls_s3;
	logic signed [NUM_W-1:0] num_s2;
	logic signed [DEN_W-1:0] den_s2;
	logic                    zdiv_s2, zdiv_s3, nonpos_s3;
	logic signed [NUM_W-1:0] num_n;
	logic signed [DEN_W-1:0] den_n;
	logic [NUM_W-1:0]        n2_s3;
	logic [DENU_W-1:0]       den_s3;
	logic                    sat;
	div_carry_t              dc_s4;
	logic [NUM_W-1:0]        rem_s4;

	logic [NUM_W-1:0]   rem_st [DEPTH_W+1];
	logic [DEPTH_W-1:0] q_st   [DEPTH_W+1];
	div_carry_t         dc_st  [DEPTH_W+1];

	pixel_class_t       cls_out_q;
	logic [DEPTH_W-1:0] depth_q;

	assign v490 = LOG_IN_W'(in_item.n490) * NLW_GAIN;
	assign v555 = LOG_IN_W'(in_item.n555) * NLW_GAIN;
	assign f490 = (irr_490 == '0) ? LOG_IN_W'(1) : LOG_IN_W'(irr_490);
	assign f555 = (irr_555 == '0) ? LOG_IN_W'(1) : LOG_IN_W'(irr_555);

	rbp_log2 u_log_n490 (.clk(clk), .en(en), .v(v490), .r(lg490));
	rbp_log2 u_log_n555 (.clk(clk), .en(en), .v(v555), .r(lg555));
	rbp_log2 u_log_f490 (.clk(clk), .en(en), .v(f490), .r(lf490));
	rbp_log2 u_log_f555 (.clk(clk), .en(en), .v(f555), .r(lf555));

	assign num_n = (den_s2 < 0) ? -num_s2 : num_s2;
	assign den_n = (den_s2 < 0) ? -den_s2 : den_s2;
	assign sat   = {1'b0, n2_s3} >= {den_s3, 16'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[LAT_BACK-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_q[0] <= in_item.cls;
			for (int i = 1; i < LAT_LOG; i++) cls_q[i] <= cls_q[i-1];

			l490_s1 <= $signed(L_W'(lg490)) - $signed(L_W'(lf490));
			l555_s1 <= $signed(L_W'(lg555)) - $signed(L_W'(lf555));
			cls_s1  <= cls_q[LAT_LOG-1];

			num_s2  <= NUM_W'(l490_s1) * K490 - NUM_W'(l555_s1) * K555;
			den_s2  <= DEN_W'(l555_s1) * DEN_K;
			zdiv_s2 <= (l555_s1 == '0);
			cls_s2  <= cls_s1;

			// rounding: (num + den/2) / den with den made positive
			n2_s3     <= num_n + NUM_W'(den_n >>> 1);
			den_s3    <= den_n[DENU_W-1:0];
			nonpos_s3 <= (num_n <= 0);
			zdiv_s3   <= zdiv_s2;
			cls_s3    <= cls_s2;

			rem_s4       <= n2_s3;
			dc_s4.cls    <= cls_s3;
			dc_s4.den    <= den_s3;
			dc_s4.fmax   <= zdiv_s3 || (!nonpos_s3 && sat);
			dc_s4.fzero  <= (cls_s3 != CLASS_WATER) || (!zdiv_s3 && nonpos_s3);
		end
	end

	assign rem_st[0] = rem_s4;
	assign q_st[0]   = '0;
	assign dc_st[0]  = dc_s4;

	for (genvar k = 0; k < DEPTH_W; k++) begin : g_div
		localparam int SH = DEPTH_W - 1 - k;
		logic [REM_W-1:0]   sub;
		logic [NUM_W-1:0]   rem_s1;
		logic [DEPTH_W-1:0] q_s1;
		div_carry_t         dc_s1;

		assign sub = REM_W'(dc_st[k].den) << SH;

		always_ff @(posedge clk) begin
			if (en) begin
				if (REM_W'(rem_st[k]) >= sub) begin
					rem_s1 <= NUM_W'(REM_W'(rem_st[k]) - sub);
					q_s1   <= q_st[k] | (DEPTH_W'(1) << SH);
				end else begin
					rem_s1 <= rem_st[k];
					q_s1   <= q_st[k];
				end
				dc_s1 <= dc_st[k];
			end
		end

		assign rem_st[k+1] = rem_s1;
		assign q_st[k+1]   = q_s1;
		assign dc_st[k+1]  = dc_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_out_q <= dc_st[DEPTH_W].cls;
			if (dc_st[DEPTH_W].fzero)
				depth_q <= '0;
			else if (dc_st[DEPTH_W].fmax)
				depth_q <= DEPTH_MAX;
			else
				depth_q <= q_st[DEPTH_W];
		end
	end

	assign out_valid = valid_q[LAT_BACK-1];
	assign out_class = cls_out_q;
	assign out_depth = depth_q;

endmodule

FILE: tb/ratio_bathymetry_pixel_checker.sv
// Checker of the ratio bathymetry pixel block: predicts every result and compares.
module ratio_bathymetry_pixel_checker import rbp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [103:0]         s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [DEPTH_W-1:0]   m_tdata,
	input  logic [CLASS_W-1:0]   m_tuser,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [IRR_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending,
	output int                   results_seen
);

	typedef struct {
		pixel_class_t     cls;
		logic [DEPTH_W-1:0] depth;
	} pixel_result_t;

	pixel_result_t depth_queue[$];
	logic [IRR_W-1:0] irr_490, irr_555;

	// Q30 cosine of an angle in 1/100 degree, Horner form with clamped stages
	function automatic longint unsigned zenith_cos(input longint unsigned t);
		longint unsigned x, x2, c, p;
		int unsigned divs[5];
		divs = '{90, 56, 30, 12, 2};
		if (t > 9000) t = 9000;
		x = t * 187403;
		x2 = (x * x) >> 30;
		c = longint'(1) << 30;
		for (int j = 0; j < 5; j++) begin
			p = ((c * x2) >> 30) / divs[j];
			c = (p >= (longint'(1) << 30)) ? 0 : (longint'(1) << 30) - p;
		end
		return c;
	endfunction

	function automatic longint log2_fix(input longint unsigned v);
		longint unsigned m, r;
		int k;
		k = 0;
		if (v == 0) v = 1;
		while (k < 40 && (v >> (k + 1)) != 0) k++;
		m = (k <= 30) ? (v << (30 - k)) : (v >> (k - 30));
		r = longint'(k) << 16;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (longint'(2) << 30)) begin
				m = m >> 1;
				r = r | (longint'(1) << i);
			end
		end
		return longint'(r);
	endfunction

	function automatic pixel_result_t predict_pixel(input logic [103:0] d);
		pixel_result_t res;
		longint mu0, mu, big_n, n490, n555, l490, l555, num, den, f490, f555, dep;
		mu0 = zenith_cos(d[13:0]);
		mu = zenith_cos(d[27:14]);
		big_n = 10 * longint'(d[45:28]) - 7 * longint'(d[63:46]);
		n490 = longint'($signed(d[81:64]));
		n555 = longint'($signed(d[99:82]));
		res.depth = '0;
		if (mu * big_n + 122880 * (mu + mu0) > 0) begin
			res.cls = CLASS_LAND;
			return res;
		end
		if (n490 <= 0 || n555 <= 0) begin
			res.cls = CLASS_NORET;
			return res;
		end
		f490 = (irr_490 != 0) ? longint'(irr_490) : 1;
		f555 = (irr_555 != 0) ? longint'(irr_555) : 1;
		l490 = log2_fix(n490 * 125) - log2_fix(f490);
		l555 = log2_fix(n555 * 125) - log2_fix(f555);
		res.cls = CLASS_WATER;
		if (l555 == 0) begin
			res.depth = DEPTH_MAX;
		end else begin
			num = 55040 * l490 - 52288 * l555;
			den = 5 * l555;
			if (den < 0) begin
				den = -den;
				num = -num;
			end
			if (num <= 0) dep = 0;
			else dep = (num + den / 2) / den;
			res.depth = (dep > 65535) ? DEPTH_MAX : dep[15:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		results_seen = 0;
	end

	assign pending = depth_queue.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t exp_res;
		if (!arst_n) begin
			irr_490 <= IRR490_RST;
			irr_555 <= IRR555_RST;
			depth_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IRR_490) irr_490 <= cfg_data;
				else if (cfg_index == REG_IRR_555) irr_555 <= cfg_data;
			end
			if (s_tvalid && s_tready) depth_queue.push_back(predict_pixel(s_tdata));
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (depth_queue.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					exp_res = depth_queue.pop_front();
					if (m_tuser !== exp_res.cls)
						report_mismatch($sformatf("pixel_class %0d, expected %0d",
							m_tuser, exp_res.cls));
					if (m_tdata !== exp_res.depth)
						report_mismatch($sformatf("depth_est %0d, expected %0d",
							m_tdata, exp_res.depth));
				end
			end
		end
	end

endmodule

FILE: tb/ratio_bathymetry_pixel_tb.sv
// Top of the ratio bathymetry pixel testbench: clock, reset, stimulus and verdict.
module ratio_bathymetry_pixel_tb;
	import rbp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;

	logic                 clk, arst_n;
	logic                 s_tvalid, s_tready;
	logic [103:0]         s_tdata;
	logic                 m_tvalid, m_tready;
	logic [DEPTH_W-1:0]   m_tdata;
	logic [CLASS_W-1:0]   m_tuser;
	logic                 cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [IRR_W-1:0]     cfg_data;
	int                   fail_count, pending, results_seen;
	int                   cycles, pixels_sent;
	logic                 hold_req, quiet;

	ratio_bathymetry_pixel DUT (.*);

	ratio_bathymetry_pixel_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	always @(negedge clk or negedge arst_n) begin
		int burst;
		if (!arst_n) begin
			m_tready <= 1'b0;
			burst = 0;
		end else if (hold_req) begin
			m_tready <= 1'b0;
			repeat (300) @(negedge clk);
			hold_req <= 1'b0;
			m_tready <= 1'b1;
		end else if (quiet) begin
			m_tready <= 1'b1;
		end else if (burst > 0) begin
			burst--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			burst = $urandom_range(1, 15) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic [103:0] make_pixel(input logic [13:0] sol, input logic [13:0] sens,
			input logic [17:0] nir, input logic [17:0] blue,
			input logic [17:0] n490, input logic [17:0] n555);
		return {4'b0, n555, n490, blue, nir, sens, sol};
	endfunction

	task automatic send_pixel(input logic [103:0] d);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15) - 1) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IRR_W-1:0] val);
		@(negedge clk);
		s_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// mostly pixels that pass the land test with positive radiances
	task automatic send_random(input int count);
		logic [103:0] d;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: d = make_pixel($urandom_range(0, 9000),
					$urandom_range(0, 8500), $urandom_range(0, 4000),
					$urandom_range(60000, 262143),
					($urandom_range(0, 1) ? $urandom_range(1, 131071) : $urandom_range(1, 4000)),
					($urandom_range(0, 1) ? $urandom_range(1, 131071) : $urandom_range(1, 4000)));
				6: d = make_pixel($urandom_range(0, 9000), $urandom_range(0, 9000),
					$urandom, $urandom, $urandom, $urandom);
				7: d = make_pixel($urandom_range(0, 9000), $urandom_range(0, 8500),
					$urandom_range(0, 4000), $urandom_range(60000, 262143),
					$urandom_range(0, 1) ? -$urandom_range(0, 131072) : $urandom,
					$urandom_range(0, 1) ? -$urandom_range(0, 131072) : $urandom);
				default: d = make_pixel($urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom);
			endcase
			send_pixel(d);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_IRR_490;
		cfg_data = '0;
		hold_req = 1'b0;
		quiet = 1'b0;
		cycles = 0;
		pixels_sent = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset register values
		send_pixel(make_pixel(0, 0, 0, 0, 0, 0));
		send_pixel(make_pixel(16383, 16383, 18'h3FFFF, 18'h3FFFF, 18'h1FFFF, 18'h1FFFF));
		send_pixel(make_pixel(9000, 9000, 0, 18'h3FFFF, 1000, 1000));
		send_pixel(make_pixel(3000, 9000, 0, 18'h3FFFF, 1000, 1000));
		send_pixel(make_pixel(9000, 12000, 0, 18'h3FFFF, 1000, 1000));
		send_pixel(make_pixel(0, 0, 18'h3FFFF, 0, 500, 500));
		send_pixel(make_pixel(0, 0, 0, 18'h3FFFF, 0, 500));
		send_pixel(make_pixel(0, 0, 0, 18'h3FFFF, 500, 18'h20000));
		send_pixel(make_pixel(0, 0, 0, 18'h3FFFF, 18'h3FFFF, 18'h20000));
		send_pixel(make_pixel(0, 0, 0, 18'h3FFFF, 1, 1));
		send_pixel(make_pixel(0, 0, 0, 18'h3FFFF, 18'h1FFFF, 1));
		send_pixel(make_pixel(0, 0, 0, 18'h3FFFF, 1, 18'h1FFFF));
		send_pixel(make_pixel(4500, 2000, 100, 150000, 2000, 1500));
		send_pixel(make_pixel(4500, 2000, 100, 150000, 1500, 1516));
		wait_idle();

		// zero log divisor: 125*n555 equals F0 at 555
		write_reg(REG_IRR_555, 18'd125000);
		write_reg(2'd2, 18'd7);
		write_reg(2'd3, 18'h3FFFF);
		send_pixel(make_pixel(1000, 1000, 0, 200000, 1000, 1000));
		send_pixel(make_pixel(1000, 1000, 0, 200000, 3000, 1000));
		send_pixel(make_pixel(1000, 1000, 0, 200000, 10, 1000));
		send_random(150);
		wait_idle();

		// zero registers count as one
		write_reg(REG_IRR_490, 18'd0);
		write_reg(REG_IRR_555, 18'd0);
		send_random(150);
		wait_idle();

		write_reg(REG_IRR_490, 18'h3FFFF);
		write_reg(REG_IRR_555, 18'h3FFFF);
		fork
			send_random(150);
			begin
				repeat (20) @(negedge clk);
				hold_req = 1'b1;
			end
		join
		wait_idle();

		write_reg(REG_IRR_490, 18'd1);
		write_reg(REG_IRR_555, 18'd200000);
		send_random(130);
		wait_idle();

		write_reg(REG_IRR_490, $urandom_range(1, 262143));
		write_reg(REG_IRR_555, $urandom_range(1, 262143));
		send_random(120);
		wait_idle();

		write_reg(REG_IRR_490, IRR490_RST);
		write_reg(REG_IRR_555, IRR555_RST);
		send_random(80);
		quiet = 1'b1;
		send_random(60);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d pixels and %0d results over seven irradiance settings,",
			pixels_sent, results_seen);
		$display("including zero, unit and full-scale registers, stalls and a long hold-off.");
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/rbp_pkg.sv
rtl/rbp_cos.sv
rtl/rbp_log2.sv
rtl/rbp_fifo.sv
rtl/rbp_front.sv
rtl/rbp_back.sv
rtl/ratio_bathymetry_pixel.sv
tb/ratio_bathymetry_pixel_checker.sv
tb/ratio_bathymetry_pixel_tb.sv
